// ===== hdl/pfta_pkg.sv =====
// ----------------------------------------------------------------------------
// pfta_pkg: shared types and constants of the pausable frame timer averager
// Event codes, register indexes, fixed field widths and the control word of
// the bit-serial adder cells.
// ----------------------------------------------------------------------------
package pfta_pkg;

   // fixed widths of the port fields
   localparam int FUNC_WIDTH      = 2;
   localparam int TS_WIDTH        = 48;
   localparam int RATE_WIDTH      = 16;
   localparam int CSR_WIDTH       = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   // event codes
   localparam logic [FUNC_WIDTH-1:0] FUNC_FRAME = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_RESET = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_START = 2'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_STOP  = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNTS_PER_SECOND = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_FRAME_COUNTS  = 2'd1;

   // register reset values
   localparam logic [CSR_WIDTH-1:0] COUNTS_PER_SECOND_RESET = 32'd10000000;
   localparam logic [CSR_WIDTH-1:0] MIN_FRAME_COUNTS_RESET  = 32'd0;

   // frame rate counter saturates here
   localparam logic [RATE_WIDTH-1:0] RATE_MAX = 16'hFFFF;

   // control word of one bit-serial adder cell
   typedef struct packed {
      logic clear;   // preset the carry for a new pass
      logic enable;  // consume one bit pair
      logic sub;     // subtract b from a instead of adding
   } serial_ctl_type;

endpackage

// ===== hdl/pfta_ram.sv =====
// ----------------------------------------------------------------------------
// pfta_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are undefined until
// written.
// ----------------------------------------------------------------------------
module pfta_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pfta_bit_adder.sv =====
// ----------------------------------------------------------------------------
// pfta_bit_adder: bit-serial add/subtract cell
// Takes one bit of each operand per enabled cycle, LSB first, and keeps the carry in
// a flop. After the last bit, carry_out is the final carry (for a subtract,
// high when a >= b).
// ----------------------------------------------------------------------------
module pfta_bit_adder (
   input  logic                     clock,
   input  pfta_pkg::serial_ctl_type ctl,
   input  logic                     a_bit,
   input  logic                     b_bit,
   output logic                     sum_bit,
   output logic                     carry_out
);
   import pfta_pkg::*;

   logic carry_ff;
   logic carry_in;
   logic b_eff;

   // full adder on the current bit pair
   assign b_eff     = b_bit ^ ctl.sub;
   assign sum_bit   = a_bit ^ b_eff ^ carry_ff;
   assign carry_out = (a_bit & b_eff) | (a_bit & carry_ff) | (b_eff & carry_ff);

   // preset carry at pass start, advance on each bit
   always_comb begin
      carry_in = carry_ff;
      if (ctl.clear) begin
         carry_in = ctl.sub;
      end else if (ctl.enable) begin
         carry_in = carry_out;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

endmodule

// ===== hdl/pfta_div.sv =====
// ----------------------------------------------------------------------------
// pfta_div: restoring divider, one quotient bit per cycle
// Divides a wide dividend by a narrow divisor after a start pulse; done pulses
// for one cycle with the quotient valid.
// ----------------------------------------------------------------------------
module pfta_div #(
   parameter int DVD_WIDTH = 54,
   parameter int DVS_WIDTH = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DVD_WIDTH-1:0] dividend,
   input  logic [DVS_WIDTH-1:0] divisor,
   output logic [DVD_WIDTH-1:0] quotient,
   output logic                 done
);

   localparam int CNT_WIDTH = $clog2(DVD_WIDTH + 1);

   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;
   logic [CNT_WIDTH-1:0] cnt_ff,   cnt_in;
   logic [DVD_WIDTH-1:0] dvd_ff,   dvd_in;
   logic [DVS_WIDTH-1:0] rem_ff,   rem_in;
   logic [DVS_WIDTH:0]   rem_shift;
   logic [DVS_WIDTH:0]   rem_diff;
   logic                 ge;

   // trial subtract of the divisor from the shifted remainder
   assign rem_shift = {rem_ff, dvd_ff[DVD_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor};
   assign ge        = (rem_shift >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift dividend out, quotient bit in
         dvd_in = {dvd_ff[DVD_WIDTH-2:0], ge};
         rem_in = ge ? rem_diff[DVS_WIDTH-1:0] : rem_shift[DVS_WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(DVD_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign quotient = dvd_ff;
   assign done     = done_ff;

endmodule

// ===== hdl/pausable_frame_timer_averager.sv =====
// ----------------------------------------------------------------------------
// pausable_frame_timer_averager: pausable frame timer with moving average
// Times events on a free-running counter, keeps paused time, a window of
// recent frame lengths and a one-second frame count, all with bit-serial
// arithmetic passes and a serial divider.
// ----------------------------------------------------------------------------
// Passes: each serial pass runs over XW bits (XW = 54 at default parameters).
//   A running frame takes four or five passes and a divide; start while
//   stopped takes two passes, other events one.
// Throughput: one word at a time; the next word is taken once the current
//   result is in the output register, which frees while the result waits.
// Reset: synchronous, active high; clears the timer state, counters, window
//   fill and registers to their defaults. Window RAM contents are not cleared.
// ----------------------------------------------------------------------------
module pausable_frame_timer_averager #(
   parameter int WINDOW_DEPTH = 64,
   parameter int TIME_WIDTH   = 48
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [pfta_pkg::FUNC_WIDTH-1:0]         req_func,
   input  logic [pfta_pkg::TS_WIDTH-1:0]           req_timestamp,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [pfta_pkg::TS_WIDTH-1:0]           rsp_avg_frame_counts,
   output logic [pfta_pkg::TS_WIDTH-1:0]           rsp_total_counts,
   output logic [pfta_pkg::RATE_WIDTH-1:0]         rsp_frame_rate,
   output logic                                    rsp_is_stopped,
   // configuration writes
   input  logic                                    csr_write_en,
   input  logic [pfta_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pfta_pkg::CSR_WIDTH-1:0]          csr_wdata
);
   import pfta_pkg::*;

   localparam int TW = TIME_WIDTH;
   localparam int SW = TIME_WIDTH + $clog2(WINDOW_DEPTH);     // window sum
   localparam int EW = TIME_WIDTH + 1;                        // rate window time
   localparam int XW = (SW > EW) ? SW : EW;                   // serial pass length
   localparam int FW = $clog2(WINDOW_DEPTH + 1);              // fill count
   localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW = $clog2(XW + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_LEN   = 3'd2;
   localparam logic [2:0] S_DIFF  = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;
   localparam logic [2:0] S_SUM   = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_TOTAL = 3'd7;

   // sequencer
   logic [2:0]            state_ff,   state_in;
   logic [CW-1:0]         cnt_ff,     cnt_in;
   // configuration
   logic [CSR_WIDTH-1:0]  cps_ff,     cps_in;
   logic [CSR_WIDTH-1:0]  min_ff,     min_in;
   // timer state
   logic [TW-1:0]         base_ff,    base_in;
   logic [TW-1:0]         prev_ff,    prev_in;
   logic [TW-1:0]         curr_ff,    curr_in;
   logic [TW-1:0]         stop_ff,    stop_in;
   logic [TW-1:0]         paused_ff,  paused_in;
   logic                  stopped_ff, stopped_in;
   logic                  first_ff,   first_in;
   // window and rate state
   logic [FW-1:0]         fill_ff,    fill_in;
   logic [SW-1:0]         sum_ff,     sum_in;
   logic [TW-1:0]         avg_ff,     avg_in;
   logic [RATE_WIDTH-1:0] frames_ff,  frames_in;
   logic [EW-1:0]         elapsed_ff, elapsed_in;
   logic [RATE_WIDTH-1:0] rate_ff,    rate_in;
   logic [PW-1:0]         wptr_ff,    wptr_in;
   // per-word scratch
   logic [TW-1:0]         ts_ff,      ts_in;
   logic [TW-1:0]         len_ff,     len_in;
   logic [TW-1:0]         diff_ff,    diff_in;
   logic                  drop_ff,    drop_in;
   // serial operand and result shift registers
   logic [XW-1:0]         opa0_ff, opa0_in, opb0_ff, opb0_in;
   logic [XW-1:0]         opa1_ff, opa1_in, opb1_ff, opb1_in;
   logic [XW-1:0]         opa2_ff, opa2_in, opb2_ff, opb2_in;
   logic [XW-1:0]         res0_ff, res0_in, res1_ff, res1_in, res2_ff, res2_in;
   // output register
   logic                  rsp_valid_ff,   rsp_valid_in;
   logic [TS_WIDTH-1:0]   rsp_avg_ff,     rsp_avg_in;
   logic [TS_WIDTH-1:0]   rsp_total_ff,   rsp_total_in;
   logic [RATE_WIDTH-1:0] rsp_rate_ff,    rsp_rate_in;
   logic                  rsp_stopped_ff, rsp_stopped_in;

   // serial cells
   serial_ctl_type ctl0, ctl1, ctl2;
   logic           a0, b0, a1, b1, a2, b2;
   logic           s0, s1, s2;
   logic           c0, c1, c2;
   logic [XW-1:0]  res0_full, res1_full, res2_full;

   // window memory and divider
   logic           ram_wr_en;
   logic           ram_rd_en;
   logic [TW-1:0]  ram_rd_data;
   logic           div_start;
   logic [SW-1:0]  div_quotient;
   logic           div_done;

   // misc control
   logic           req_fire;
   logic           pass_state;
   logic           out_free;
   logic           shift_en;
   logic           last_bit;
   logic           min_nz;
   logic           lock;
   logic           accept;
   logic           close_window;
   logic [TW-1:0]  ts_now;
   logic [RATE_WIDTH-1:0] frames_inc;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign ts_now     = TW'(req_timestamp);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pass_state = (state_ff == S_START) || (state_ff == S_LEN) ||
                       (state_ff == S_DIFF) || (state_ff == S_CMP) ||
                       (state_ff == S_SUM) || (state_ff == S_TOTAL);
   assign last_bit   = (cnt_ff == CW'(XW));
   // the total pass holds on its last bit until the output register frees
   assign shift_en   = pass_state && (cnt_ff != '0) &&
                       !((state_ff == S_TOTAL) && last_bit && !out_free);
   assign min_nz     = (min_ff != '0);

   // cell operands: bit zero of each shifter, chained where a pass needs it
   always_comb begin
      a0 = opa0_ff[0];
      b0 = opb0_ff[0];
      a1 = opa1_ff[0];
      b1 = opb1_ff[0];
      a2 = opa2_ff[0];
      b2 = opb2_ff[0];
      ctl0 = '{clear: 1'b0, enable: shift_en, sub: 1'b1};
      ctl1 = '{clear: 1'b0, enable: shift_en, sub: 1'b1};
      ctl2 = '{clear: 1'b0, enable: shift_en, sub: 1'b0};
      unique case (state_ff)
         S_START: begin
            // paused + (ts - stop)
            a1       = opa1_ff[0];
            b1       = s0;
            ctl1.sub = 1'b0;
         end
         S_LEN: begin
            // len = ts - prev, len < min, prev + min
            a1 = s0 & (cnt_ff <= CW'(TW));
         end
         S_SUM: begin
            // sum + len - oldest
            ctl0.sub = 1'b0;
            a1       = s0;
         end
         S_TOTAL: begin
            // T - paused - base
            a1 = s0;
         end
         default: begin
         end
      endcase
      ctl0.clear = pass_state && (cnt_ff == '0);
      ctl1.clear = pass_state && (cnt_ff == '0);
      ctl2.clear = pass_state && (cnt_ff == '0);
   end

   pfta_bit_adder u_cell0 (
      .clock     (clock),
      .ctl       (ctl0),
      .a_bit     (a0),
      .b_bit     (b0),
      .sum_bit   (s0),
      .carry_out (c0)
   );

   pfta_bit_adder u_cell1 (
      .clock     (clock),
      .ctl       (ctl1),
      .a_bit     (a1),
      .b_bit     (b1),
      .sum_bit   (s1),
      .carry_out (c1)
   );

   pfta_bit_adder u_cell2 (
      .clock     (clock),
      .ctl       (ctl2),
      .a_bit     (a2),
      .b_bit     (b2),
      .sum_bit   (s2),
      .carry_out (c2)
   );

   // results with the current bit shifted in
   assign res0_full = {s0, res0_ff[XW-1:1]};
   assign res1_full = {s1, res1_ff[XW-1:1]};
   assign res2_full = {s2, res2_ff[XW-1:1]};

   // decisions taken on the last bit of a pass
   assign lock         = min_nz && !c1;
   assign accept       = !first_ff && !c0;
   assign close_window = !c1;
   assign frames_inc   = (frames_ff == RATE_MAX) ? frames_ff : frames_ff + 1'b1;

   pfta_ram #(
      .WIDTH (TW),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wptr_ff),
      .wr_data (len_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (wptr_ff),
      .rd_data (ram_rd_data)
   );

   pfta_div #(
      .DVD_WIDTH (SW),
      .DVS_WIDTH (FW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // sequencer and datapath next state
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cps_in      = cps_ff;
      min_in      = min_ff;
      base_in     = base_ff;
      prev_in     = prev_ff;
      curr_in     = curr_ff;
      stop_in     = stop_ff;
      paused_in   = paused_ff;
      stopped_in  = stopped_ff;
      first_in    = first_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      avg_in      = avg_ff;
      frames_in   = frames_ff;
      elapsed_in  = elapsed_ff;
      rate_in     = rate_ff;
      wptr_in     = wptr_ff;
      ts_in       = ts_ff;
      len_in      = len_ff;
      diff_in     = diff_ff;
      drop_in     = drop_ff;
      opa0_in     = opa0_ff;
      opb0_in     = opb0_ff;
      opa1_in     = opa1_ff;
      opb1_in     = opb1_ff;
      opa2_in     = opa2_ff;
      opb2_in     = opb2_ff;
      res0_in     = res0_ff;
      res1_in     = res1_ff;
      res2_in     = res2_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_avg_in     = rsp_avg_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_rate_in    = rsp_rate_ff;
      rsp_stopped_in = rsp_stopped_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      div_start   = 1'b0;

      // configuration writes; indexes beyond the list are dropped
      if (csr_write_en) begin
         if (csr_index == CSR_COUNTS_PER_SECOND) begin
            cps_in = csr_wdata;
         end else if (csr_index == CSR_MIN_FRAME_COUNTS) begin
            min_in = csr_wdata;
         end
      end

      // load operands at pass start, then shift one bit per cycle while not held on the output register
      if (pass_state && (cnt_ff == '0)) begin
         cnt_in = CW'(1);
         unique case (state_ff)
            S_START: begin
               opa0_in = XW'(ts_ff);
               opb0_in = XW'(stop_ff);
               opa1_in = XW'(paused_ff);
               opb1_in = '0;
               opa2_in = '0;
               opb2_in = '0;
            end
            S_LEN: begin
               opa0_in   = XW'(ts_ff);
               opb0_in   = XW'(prev_ff);
               opa1_in   = '0;
               opb1_in   = XW'(min_ff);
               opa2_in   = XW'(prev_ff);
               opb2_in   = XW'(min_ff);
               ram_rd_en = 1'b1;
            end
            S_DIFF: begin
               opa0_in = XW'(len_ff);
               opb0_in = XW'(avg_ff);
               opa1_in = XW'(avg_ff);
               opb1_in = XW'(len_ff);
               opa2_in = XW'(elapsed_ff);
               opb2_in = first_ff ? '0 : XW'(avg_ff);
            end
            S_CMP: begin
               opa0_in = XW'(diff_ff);
               opb0_in = XW'(cps_ff);
               opa1_in = XW'(cps_ff);
               opb1_in = XW'(elapsed_ff);
               opa2_in = '0;
               opb2_in = '0;
            end
            S_SUM: begin
               opa0_in = XW'(sum_ff);
               opb0_in = XW'(len_ff);
               opa1_in = '0;
               opb1_in = drop_ff ? XW'(ram_rd_data) : '0;
               opa2_in = '0;
               opb2_in = '0;
            end
            default: begin
               // total pass
               opa0_in = stopped_ff ? XW'(stop_ff) : XW'(curr_ff);
               opb0_in = XW'(paused_ff);
               opa1_in = '0;
               opb1_in = XW'(base_ff);
               opa2_in = '0;
               opb2_in = '0;
            end
         endcase
      end else if (shift_en) begin
         opa0_in = {1'b0, opa0_ff[XW-1:1]};
         opb0_in = {1'b0, opb0_ff[XW-1:1]};
         opa1_in = {1'b0, opa1_ff[XW-1:1]};
         opb1_in = {1'b0, opb1_ff[XW-1:1]};
         opa2_in = {1'b0, opa2_ff[XW-1:1]};
         opb2_in = {1'b0, opb2_ff[XW-1:1]};
         res0_in = res0_full;
         res1_in = res1_full;
         res2_in = res2_full;
         cnt_in  = cnt_ff + 1'b1;
         if (last_bit) begin
            cnt_in = '0;
            // commit the finished pass
            unique case (state_ff)
               S_START: begin
                  paused_in  = res1_full[TW-1:0];
                  prev_in    = ts_ff;
                  stop_in    = '0;
                  stopped_in = 1'b0;
                  state_in   = S_TOTAL;
               end
               S_LEN: begin
                  len_in   = lock ? TW'(min_ff) : res0_full[TW-1:0];
                  curr_in  = lock ? res2_full[TW-1:0] : ts_ff;
                  prev_in  = lock ? res2_full[TW-1:0] : ts_ff;
                  state_in = S_DIFF;
               end
               S_DIFF: begin
                  diff_in    = c0 ? res0_full[TW-1:0] : res1_full[TW-1:0];
                  elapsed_in = res2_full[EW-1:0];
                  state_in   = S_CMP;
               end
               S_CMP: begin
                  first_in = 1'b0;
                  if (close_window) begin
                     rate_in    = frames_inc;
                     frames_in  = '0;
                     elapsed_in = '0;
                  end else begin
                     frames_in = frames_inc;
                  end
                  if (accept) begin
                     // write the new length at the write pointer, over the oldest slot once full
                     drop_in   = (fill_ff == FW'(WINDOW_DEPTH));
                     fill_in   = (fill_ff == FW'(WINDOW_DEPTH)) ? fill_ff : fill_ff + 1'b1;
                     ram_wr_en = 1'b1;
                     wptr_in   = (wptr_ff == PW'(WINDOW_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
                     state_in  = S_SUM;
                  end else begin
                     state_in = S_DIV;
                  end
               end
               S_SUM: begin
                  sum_in   = res1_full[SW-1:0];
                  state_in = S_DIV;
               end
               default: begin
                  // total pass: hand the result to the output register
                  rsp_valid_in   = 1'b1;
                  rsp_avg_in     = TS_WIDTH'(avg_ff);
                  rsp_total_in   = TS_WIDTH'(res1_full[TW-1:0]);
                  rsp_rate_in    = rate_ff;
                  rsp_stopped_in = stopped_ff;
                  state_in       = S_IDLE;
               end
            endcase
         end
      end

      // divide sum by fill
      if (state_ff == S_DIV) begin
         if (cnt_ff == '0) begin
            div_start = 1'b1;
            cnt_in    = CW'(1);
         end else if (div_done) begin
            avg_in   = (fill_ff == '0) ? '0 : div_quotient[TW-1:0];
            cnt_in   = '0;
            state_in = S_TOTAL;
         end
      end

      // take a new word
      if (req_fire) begin
         ts_in  = ts_now;
         cnt_in = '0;
         unique case (req_func)
            FUNC_FRAME: begin
               if (stopped_ff) begin
                  avg_in   = '0;
                  state_in = S_TOTAL;
               end else begin
                  state_in = S_LEN;
               end
            end
            FUNC_RESET: begin
               base_in    = ts_now;
               prev_in    = ts_now;
               stop_in    = '0;
               stopped_in = 1'b0;
               state_in   = S_TOTAL;
            end
            FUNC_START: begin
               state_in = stopped_ff ? S_START : S_TOTAL;
            end
            default: begin
               // stop
               if (!stopped_ff) begin
                  stop_in    = ts_now;
                  stopped_in = 1'b1;
               end
               state_in = S_TOTAL;
            end
         endcase
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cps_ff       <= COUNTS_PER_SECOND_RESET;
         min_ff       <= MIN_FRAME_COUNTS_RESET;
         base_ff      <= '0;
         prev_ff      <= '0;
         curr_ff      <= '0;
         stop_ff      <= '0;
         paused_ff    <= '0;
         stopped_ff   <= 1'b0;
         first_ff     <= 1'b1;
         fill_ff      <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         frames_ff    <= '0;
         elapsed_ff   <= '0;
         rate_ff      <= '0;
         wptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cps_ff       <= cps_in;
         min_ff       <= min_in;
         base_ff      <= base_in;
         prev_ff      <= prev_in;
         curr_ff      <= curr_in;
         stop_ff      <= stop_in;
         paused_ff    <= paused_in;
         stopped_ff   <= stopped_in;
         first_ff     <= first_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         frames_ff    <= frames_in;
         elapsed_ff   <= elapsed_in;
         rate_ff      <= rate_in;
         wptr_ff      <= wptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ts_ff          <= ts_in;
      len_ff         <= len_in;
      diff_ff        <= diff_in;
      drop_ff        <= drop_in;
      opa0_ff        <= opa0_in;
      opb0_ff        <= opb0_in;
      opa1_ff        <= opa1_in;
      opb1_ff        <= opb1_in;
      opa2_ff        <= opa2_in;
      opb2_ff        <= opb2_in;
      res0_ff        <= res0_in;
      res1_ff        <= res1_in;
      res2_ff        <= res2_in;
      rsp_avg_ff     <= rsp_avg_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_rate_ff    <= rsp_rate_in;
      rsp_stopped_ff <= rsp_stopped_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_avg_frame_counts = rsp_avg_ff;
   assign rsp_total_counts     = rsp_total_ff;
   assign rsp_frame_rate       = rsp_rate_ff;
   assign rsp_is_stopped       = rsp_stopped_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the pausable frame timer averager
// Sends frame, reset, start and stop words, predicts every response with a
// cycle-free model of the timer held in a scoreboard, and checks each
// response field by field. Covers several register settings, including the
// extremes, counter wrap, frame locking and backpressure on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import pfta_pkg::*;

   localparam int DEPTH           = 64;
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int HOLD_OFF_CYCLES = 2000;
   localparam int TAIL_CYCLES     = 400;

   // indexes outside the register map, written to check they are dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_HI = 2'd3;

   typedef struct packed {
      logic [TS_WIDTH-1:0]   avg_frame_counts;
      logic [TS_WIDTH-1:0]   total_counts;
      logic [RATE_WIDTH-1:0] frame_rate;
      logic                  is_stopped;
   } timer_word_t;

   // predicted timer state and the queue of responses still to come
   class frame_timer_scoreboard;
      bit [CSR_WIDTH-1:0]  counts_per_sec;
      bit [CSR_WIDTH-1:0]  min_frame;
      bit [TS_WIDTH-1:0]   base_t, prev_t, curr_t, stop_t, paused_t;
      bit                  stopped;
      bit                  first_frame;
      bit [TS_WIDTH-1:0]   lengths [DEPTH];
      int unsigned         fill;
      bit [53:0]           len_sum;
      bit [TS_WIDTH-1:0]   avg_len;
      bit [RATE_WIDTH-1:0] frames_seen;
      bit [RATE_WIDTH-1:0] rate;
      bit [48:0]           elapsed;
      timer_word_t         awaited [$];
      int                  mismatches;

      function new();
         counts_per_sec = COUNTS_PER_SECOND_RESET;
         min_frame      = MIN_FRAME_COUNTS_RESET;
         first_frame    = 1'b1;
         mismatches     = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_WIDTH-1:0] val);
         case (idx)
            CSR_COUNTS_PER_SECOND: counts_per_sec = val;
            CSR_MIN_FRAME_COUNTS:  min_frame = val;
            default: ;
         endcase
      endfunction

      // measure one frame, filter it into the window and update the rate count
      function void advance_frame(bit [TS_WIDTH-1:0] ts);
         bit [TS_WIDTH-1:0] len;
         bit [TS_WIDTH-1:0] diff;
         bit [TS_WIDTH-1:0] old_avg;
         if (stopped) begin
            avg_len = '0;
            return;
         end
         len    = ts - prev_t;
         curr_t = ts;
         if (min_frame != 0 && len < min_frame) begin
            len    = min_frame;
            curr_t = prev_t + min_frame;
         end
         prev_t  = curr_t;
         old_avg = avg_len;
         diff    = (len >= old_avg) ? len - old_avg : old_avg - len;
         // shift the length in, dropping the oldest once full
         if (!first_frame && diff < counts_per_sec) begin
            if (fill >= DEPTH) begin
               len_sum -= lengths[DEPTH-1];
            end else begin
               fill++;
            end
            for (int i = DEPTH - 1; i > 0; i--) lengths[i] = lengths[i-1];
            lengths[0] = len;
            len_sum   += len;
         end
         // count frames over roughly one second of average lengths
         if (frames_seen != RATE_MAX) frames_seen++;
         if (!first_frame) elapsed += old_avg;
         if (elapsed > counts_per_sec) begin
            rate        = frames_seen;
            frames_seen = '0;
            elapsed     = '0;
         end
         avg_len     = (fill > 0) ? len_sum / fill : '0;
         first_frame = 1'b0;
      endfunction

      // note an accepted request word and queue the response it causes
      function void note_word(logic [FUNC_WIDTH-1:0] func, logic [TS_WIDTH-1:0] ts);
         bit [TS_WIDTH-1:0] t;
         bit [TS_WIDTH-1:0] total;
         case (func)
            FUNC_FRAME: advance_frame(ts);
            FUNC_RESET: begin
               base_t  = ts;
               prev_t  = ts;
               stop_t  = '0;
               stopped = 1'b0;
            end
            FUNC_START: begin
               if (stopped) begin
                  paused_t = paused_t + (ts - stop_t);
                  prev_t   = ts;
                  stop_t   = '0;
                  stopped  = 1'b0;
               end
            end
            FUNC_STOP: begin
               if (!stopped) begin
                  stop_t  = ts;
                  stopped = 1'b1;
               end
            end
         endcase
         t     = stopped ? stop_t : curr_t;
         total = t - paused_t - base_t;
         awaited.push_back(timer_word_t'{avg_len, total, rate, stopped});
      endfunction

      // compare a response word against the oldest prediction
      function void check_result(timer_word_t got);
         timer_word_t exp;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response with nothing pending avg=%0d total=%0d rate=%0d stop=%0b",
                        got.avg_frame_counts, got.total_counts, got.frame_rate, got.is_stopped);
            return;
         end
         exp = awaited.pop_front();
         if (got.avg_frame_counts !== exp.avg_frame_counts ||
             got.total_counts !== exp.total_counts ||
             got.frame_rate !== exp.frame_rate ||
             got.is_stopped !== exp.is_stopped) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: expected avg=%0d total=%0d rate=%0d stop=%0b",
                        exp.avg_frame_counts, exp.total_counts, exp.frame_rate, exp.is_stopped);
               $display("       actual   avg=%0d total=%0d rate=%0d stop=%0b",
                        got.avg_frame_counts, got.total_counts, got.frame_rate, got.is_stopped);
            end
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [FUNC_WIDTH-1:0]      req_func;
   logic [TS_WIDTH-1:0]        req_timestamp;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [TS_WIDTH-1:0]        rsp_avg_frame_counts;
   logic [TS_WIDTH-1:0]        rsp_total_counts;
   logic [RATE_WIDTH-1:0]      rsp_frame_rate;
   logic                       rsp_is_stopped;
   logic                       csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0]       csr_wdata;

   frame_timer_scoreboard sb;
   bit                    calm;
   bit                    hold_request;
   int                    cycles;

   pausable_frame_timer_averager uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_timestamp        (req_timestamp),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_avg_frame_counts (rsp_avg_frame_counts),
      .rsp_total_counts     (rsp_total_counts),
      .rsp_frame_rate       (rsp_frame_rate),
      .rsp_is_stopped       (rsp_is_stopped),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // abort a hung run
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // drive response ready: random stalls, one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 9);
         end
      end
   end

   // check every accepted response word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(timer_word_t'{rsp_avg_frame_counts, rsp_total_counts,
                                       rsp_frame_rate, rsp_is_stopped});
   end

   // offer one request word and hold it until accepted
   task automatic send_word(logic [FUNC_WIDTH-1:0] func, logic [TS_WIDTH-1:0] ts);
      if (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_timestamp <= ts;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(func, ts);
   endtask

   // stop sending and wait for every pending response
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_WIDTH-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.write_register(idx, val);
   endtask

   // one setting of the registers, then mostly well-formed frame traffic
   task automatic run_phase(logic [CSR_WIDTH-1:0] cps, logic [CSR_WIDTH-1:0] min_len,
                            longint unsigned nom, longint unsigned spread, int count,
                            bit quiet, logic [TS_WIDTH-1:0] start_t, bit hold);
      logic [TS_WIDTH-1:0]   t;
      longint unsigned       delta;
      longint unsigned       rnd;
      int                    pick;
      logic [FUNC_WIDTH-1:0] f;
      drain();
      write_csr(CSR_COUNTS_PER_SECOND, cps);
      write_csr(CSR_MIN_FRAME_COUNTS, min_len);
      calm = quiet;
      t    = start_t;
      for (int n = 0; n < count; n++) begin
         if (hold && n == 20) hold_request = 1'b1;
         pick = $urandom_range(99);
         rnd  = {$urandom, $urandom};
         if (pick < 80) begin
            // frame near the nominal length, a few far outside the filter
            if (pick < 4) begin
               delta = nom + spread + 3 * longint'(cps) + rnd[31:0];
            end else begin
               delta = nom - spread + rnd % (2 * spread + 1);
            end
            t = t + delta;
            send_word(FUNC_FRAME, t);
         end else if (pick < 88) begin
            t = t + rnd % (nom + 1);
            send_word(FUNC_STOP, t);
         end else if (pick < 96) begin
            t = t + rnd % (4 * nom + 1);
            send_word(FUNC_START, t);
         end else if (pick < 98) begin
            send_word(FUNC_RESET, t);
         end else begin
            // noise: any event at any time
            f = $urandom_range(FUNC_STOP, FUNC_FRAME);
            send_word(f, rnd[TS_WIDTH-1:0]);
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      logic [CSR_WIDTH-1:0] rand_cps;
      logic [CSR_WIDTH-1:0] rand_min;
      sb            = new();
      calm          = 1'b0;
      hold_request  = 1'b0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_func      <= FUNC_FRAME;
      req_timestamp <= '0;
      csr_write_en  <= 1'b0;
      csr_index     <= CSR_COUNTS_PER_SECOND;
      csr_wdata     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: first frame, filter, pause handling, resets and wrap
      send_word(FUNC_FRAME, 48'd0);
      send_word(FUNC_FRAME, 48'd166_666);
      send_word(FUNC_FRAME, 48'd333_332);
      send_word(FUNC_FRAME, 48'd333_332);
      send_word(FUNC_FRAME, 48'd40_333_332);
      send_word(FUNC_STOP, 48'd40_400_000);
      send_word(FUNC_STOP, 48'd40_500_000);
      send_word(FUNC_FRAME, 48'd40_600_000);
      send_word(FUNC_START, 48'd41_000_000);
      send_word(FUNC_START, 48'd41_100_000);
      send_word(FUNC_FRAME, 48'd41_166_666);
      send_word(FUNC_RESET, 48'hFFFF_FFFF_FF00);
      send_word(FUNC_FRAME, 48'hFFFF_FFFF_FFFF);
      send_word(FUNC_FRAME, 48'd100);
      send_word(FUNC_STOP, 48'hFFFF_FFFF_FFF0);
      send_word(FUNC_START, 48'd16);
      send_word(FUNC_FRAME, 48'd200);
      send_word(FUNC_FRAME, 48'hFFFF_FFFF_FFFF);
      send_word(FUNC_RESET, 48'd0);
      send_word(FUNC_FRAME, 48'd0);
      send_word(FUNC_FRAME, 48'd1);

      // random phases over several register settings
      run_phase(32'd10_000_000, 32'd0, 166_666, 4_000, 250, 1'b0,
                {$urandom, $urandom}, 1'b0);
      run_phase(32'd1000, 32'd0, 100, 90, 250, 1'b1, 48'hFFFF_FFFF_EC78, 1'b0);
      run_phase(32'd1000, 32'd150, 120, 100, 200, 1'b0, {$urandom, $urandom}, 1'b1);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd1 << 32, 64'd1 << 30, 150, 1'b0,
                {$urandom, $urandom}, 1'b0);
      drain();
      write_csr(CSR_UNMAPPED_LO, $urandom);
      write_csr(CSR_UNMAPPED_HI, 32'hFFFF_FFFF);
      run_phase(32'd1, 32'd0, 2, 2, 150, 1'b0, {$urandom, $urandom}, 1'b0);
      run_phase(32'd0, 32'd1, 50, 50, 100, 1'b0, {$urandom, $urandom}, 1'b0);
      rand_cps = $urandom | 32'h100;
      rand_min = $urandom_range(1) ? $urandom_range(rand_cps / 8) : 32'd0;
      run_phase(rand_cps, rand_min, rand_cps / 8 + 1, rand_cps / 16, 150, 1'b0,
                {$urandom, $urandom}, 1'b0);

      // let the last responses land, then report
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
